// ===== rtl/phsss_pkg.sv =====
// Shared types, register codes, reset values and helper functions for the
// peg-hole spiral search sequencer. No dependencies.
package phsss_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int CAPTURE_LIMIT_DEF   = 10;

   // Register indexes on the CSR port
   localparam logic [2:0] CSR_CONTACT_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_SLIDE_THRESHOLD   = 3'd1;
   localparam logic [2:0] CSR_APPROACH_OFFSET   = 3'd2;
   localparam logic [2:0] CSR_CONTACT_OFFSET    = 3'd3;
   localparam logic [2:0] CSR_SLIDE_OFFSET      = 3'd4;
   localparam logic [2:0] CSR_START_RADIUS      = 3'd5;
   localparam logic [2:0] CSR_RADIUS_STEP       = 3'd6;
   localparam logic [2:0] CSR_ANGLE_STEP        = 3'd7;

   localparam logic [14:0]        CONTACT_THRESHOLD_RST = 15'd64;
   localparam logic signed [15:0] SLIDE_THRESHOLD_RST   = -16'sd640;
   localparam logic [22:0]        APPROACH_OFFSET_RST   = 23'd100000;
   localparam logic [22:0]        CONTACT_OFFSET_RST    = 23'd10000;
   localparam logic [22:0]        SLIDE_OFFSET_RST      = 23'd50000;
   localparam logic [22:0]        START_RADIUS_RST      = 23'd10000;
   localparam logic [22:0]        RADIUS_STEP_RST       = 23'd15000;
   localparam logic [15:0]        ANGLE_STEP_RST        = 16'd104;

   localparam logic [5:0] GAIN_X_ONLY = 6'h01;
   localparam logic [5:0] GAIN_ALL    = 6'h3F;
   localparam logic [3:0] COUNT_MAX   = 4'hF;

   // Taylor series constants for the sine table build
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef enum logic [1:0] {
      PH_APPROACH = 2'd0,
      PH_SEARCH   = 2'd1,
      PH_SLIDE    = 2'd2,
      PH_PRESS    = 2'd3
   } phase_type;

   typedef struct packed {
      logic signed [15:0] force_x;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [23:0] target_z;
      logic [5:0]         gain_mask;
      phase_type          phase;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        contact_threshold;
      logic signed [15:0] slide_threshold;
      logic [22:0]        approach_offset;
      logic [22:0]        contact_offset;
      logic [22:0]        slide_offset;
      logic [22:0]        start_radius;
      logic [22:0]        radius_step;
      logic [15:0]        angle_step;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [3:0]         capture_count;
      logic [15:0]        spiral_angle;
      logic [22:0]        spiral_radius;
      logic signed [23:0] hit_y;
      logic signed [23:0] hit_z;
      logic signed [23:0] last_x;
      logic signed [23:0] last_y;
      logic signed [23:0] last_z;
      logic [5:0]         last_gain;
   } state_type;

   // Clamp a 25-bit sum to the signed 24-bit range
   function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
      logic signed [23:0] r;
      if (v[24] != v[23]) begin
         r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // Q15 sine of q quarter-table steps, 2^qbits steps per quarter turn.
   // Elaboration only: it builds the constant quarter-wave table.
   function automatic logic [14:0] quarter_sine(input int unsigned q,
                                                input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (64'(q) * HALF_PI_Q30) >> qbits;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 5; k++) begin
         t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[k]);
      end
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

// ===== rtl/phsss_sine.sv =====
// Quarter-wave folded sine/cosine lookup from a constant table.
// Depends on phsss_pkg (table build function).
module phsss_sine #(
   parameter int TABLE_BITS = phsss_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic [TABLE_BITS-1:0] idx,
   output logic signed [15:0]    sin_val,
   output logic signed [15:0]    cos_val
);
   import phsss_pkg::*;

   localparam int QBITS = TABLE_BITS - 2;
   localparam int QTR   = 1 << QBITS;
   localparam logic [TABLE_BITS-1:0] QTR_IDX  = TABLE_BITS'(QTR);
   localparam logic [TABLE_BITS-2:0] QTR_ADDR = (TABLE_BITS-1)'(QTR);

   logic [14:0] rom [QTR+1];

   for (genvar g = 0; g <= QTR; g++) begin : g_rom
      localparam logic [14:0] ENTRY = quarter_sine(g, QBITS);
      assign rom[g] = ENTRY;
   end

   logic [TABLE_BITS-1:0] cidx;
   logic [1:0]            s_quad, c_quad;
   logic [TABLE_BITS-2:0] s_addr, c_addr;
   logic [14:0]           s_mag, c_mag;

   assign cidx   = idx + QTR_IDX;
   assign s_quad = idx[TABLE_BITS-1 -: 2];
   assign c_quad = cidx[TABLE_BITS-1 -: 2];

   always_comb begin
      // odd quadrants run the table backward
      s_addr = s_quad[0] ? QTR_ADDR - {1'b0, idx[QBITS-1:0]} : {1'b0, idx[QBITS-1:0]};
      c_addr = c_quad[0] ? QTR_ADDR - {1'b0, cidx[QBITS-1:0]} : {1'b0, cidx[QBITS-1:0]};
      s_mag  = rom[s_addr];
      c_mag  = rom[c_addr];
      sin_val = s_quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      cos_val = c_quad[1] ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
   end

endmodule

// ===== rtl/phsss_step.sv =====
// One control tick: phase sequencing, spiral stepping and target forming.
// Depends on phsss_pkg and phsss_sine.
module phsss_step #(
   parameter int SINE_TABLE_BITS = phsss_pkg::SINE_TABLE_BITS_DEF,
   parameter int CAPTURE_LIMIT   = phsss_pkg::CAPTURE_LIMIT_DEF
) (
   input  phsss_pkg::cfg_type   cfg,
   input  phsss_pkg::state_type state_cur,
   input  phsss_pkg::req_type   req,
   output phsss_pkg::state_type state_nxt,
   output phsss_pkg::rsp_type   rsp
);
   import phsss_pkg::*;

   localparam logic [3:0] CAP_LIMIT = 4'(CAPTURE_LIMIT);

   // round(r * s / 32768), half away from zero
   function automatic logic signed [23:0] scale_q15(input logic [22:0] r,
                                                    input logic signed [15:0] s);
      logic [15:0] s_abs;
      logic [38:0] prod;
      logic [23:0] mag;
      s_abs = s[15] ? 16'(-s) : 16'(s);
      prod  = 39'(r) * 39'(s_abs) + 39'd16384;
      mag   = prod[38:15];
      return s[15] ? -$signed(mag) : $signed(mag);
   endfunction

   logic signed [16:0] fx_ext;
   logic [16:0]        fx_mag;
   logic               light;
   logic               capture;
   logic               slide_on;
   logic [22:0]        lead_off;
   logic signed [23:0] lead_x;
   logic [16:0]        angle_sum;
   logic               wrap;
   logic [15:0]        angle_new;
   logic [23:0]        radius_sum;
   logic [22:0]        radius_new;
   logic signed [15:0] sin_val, cos_val;
   logic signed [23:0] spiral_y, spiral_z;
   phase_type          phase_nxt;

   assign fx_ext   = 17'(req.force_x);
   assign fx_mag   = fx_ext[16] ? 17'(-fx_ext) : 17'(fx_ext);
   assign light    = fx_mag < {2'b0, cfg.contact_threshold};
   assign capture  = state_cur.capture_count <= CAP_LIMIT;
   assign slide_on = $signed(req.force_x) > $signed(cfg.slide_threshold);

   always_comb begin
      case (state_cur.phase)
         PH_APPROACH: lead_off = cfg.approach_offset;
         PH_SLIDE:    lead_off = cfg.slide_offset;
         default:     lead_off = cfg.contact_offset;
      endcase
   end

   assign lead_x = sat24($signed({req.pos_x[23], req.pos_x}) + $signed({2'b0, lead_off}));

   // spiral advance: full turn clears the angle and grows the radius
   assign angle_sum  = {1'b0, state_cur.spiral_angle} + {1'b0, cfg.angle_step};
   assign wrap       = angle_sum[16];
   assign angle_new  = wrap ? 16'd0 : angle_sum[15:0];
   assign radius_sum = {1'b0, state_cur.spiral_radius} + {1'b0, cfg.radius_step};
   assign radius_new = !wrap ? state_cur.spiral_radius
                     : (radius_sum[23] ? 23'h7FFFFF : radius_sum[22:0]);

   phsss_sine #(
      .TABLE_BITS(SINE_TABLE_BITS)
   ) u_sine (
      .idx    (angle_new[15 -: SINE_TABLE_BITS]),
      .sin_val(sin_val),
      .cos_val(cos_val)
   );

   assign spiral_y = sat24($signed({state_cur.hit_y[23], state_cur.hit_y})
                         + 25'(scale_q15(radius_new, cos_val)));
   assign spiral_z = sat24($signed({state_cur.hit_z[23], state_cur.hit_z})
                         + 25'(scale_q15(radius_new, sin_val)));

   // next phase
   always_comb begin
      phase_nxt = state_cur.phase;
      unique case (state_cur.phase)
         PH_APPROACH: if (!light) phase_nxt = PH_SEARCH;
         PH_SEARCH:   if (light) phase_nxt = PH_SLIDE;
         PH_SLIDE:    if (!slide_on) phase_nxt = PH_PRESS;
         PH_PRESS:    phase_nxt = PH_PRESS;
      endcase
   end

   // result; an approach or slide branch that changes phase repeats the previous target
   always_comb begin
      rsp.target_x  = state_cur.last_x;
      rsp.target_y  = state_cur.last_y;
      rsp.target_z  = state_cur.last_z;
      rsp.gain_mask = state_cur.last_gain;
      rsp.phase     = phase_nxt;
      unique case (state_cur.phase)
         PH_APPROACH: begin
            if (light) begin
               rsp.target_x  = lead_x;
               rsp.target_y  = req.pos_y;
               rsp.target_z  = req.pos_z;
               rsp.gain_mask = GAIN_X_ONLY;
            end
         end
         PH_SEARCH: begin
            if (capture) begin
               rsp.target_x = req.pos_x;
               rsp.target_y = req.pos_y;
               rsp.target_z = req.pos_z;
            end else begin
               rsp.target_x = lead_x;
               rsp.target_y = spiral_y;
               rsp.target_z = spiral_z;
            end
            rsp.gain_mask = GAIN_ALL;
         end
         PH_SLIDE: begin
            if (slide_on) begin
               rsp.target_x  = lead_x;
               rsp.target_y  = req.pos_y;
               rsp.target_z  = req.pos_z;
               rsp.gain_mask = GAIN_ALL;
            end
         end
         PH_PRESS: begin
            rsp.target_x  = lead_x;
            rsp.target_y  = req.pos_y;
            rsp.target_z  = req.pos_z;
            rsp.gain_mask = GAIN_ALL;
         end
      endcase
   end

   // state update
   always_comb begin
      state_nxt       = state_cur;
      state_nxt.phase = phase_nxt;
      if (state_cur.phase == PH_SEARCH) begin
         if (capture) begin
            state_nxt.hit_y         = req.pos_y;
            state_nxt.hit_z         = req.pos_z;
            state_nxt.spiral_angle  = 16'd0;
            state_nxt.spiral_radius = cfg.start_radius;
            if (state_cur.capture_count != COUNT_MAX) begin
               state_nxt.capture_count = state_cur.capture_count + 4'd1;
            end
         end else begin
            state_nxt.spiral_angle  = angle_new;
            state_nxt.spiral_radius = radius_new;
         end
      end
      state_nxt.last_x    = rsp.target_x;
      state_nxt.last_y    = rsp.target_y;
      state_nxt.last_z    = rsp.target_z;
      state_nxt.last_gain = rsp.gain_mask;
   end

endmodule

// ===== rtl/peg_hole_spiral_search_sequencer_core.sv =====
// Top level of the peg-hole spiral search sequencer: input register, CSRs,
// sequencer state and result register. Depends on phsss_pkg and phsss_step.
//
// Each request transaction is one control tick (force_x, pos_x/y/z) and
// yields exactly one response transaction (target x/y/z, gain_mask, phase).
// The block takes one transaction per cycle while the output is not blocked.
// An accepted tick is held in the input register, then moves into the result
// register, which raises rsp_valid. A blocked result register holds the input
// register too, and input stalls only while both are full. The per-tick state
// (phase, capture count, spiral angle and radius, hit point, last target)
// closes through the combinational step logic, which sets the one-per-cycle
// figure. The sine table is constant logic built at elaboration, so no
// start-up pass is needed after reset.
// Write CSRs only while no transaction is in flight.
module peg_hole_spiral_search_sequencer_core #(
   parameter int SINE_TABLE_BITS = phsss_pkg::SINE_TABLE_BITS_DEF,
   parameter int CAPTURE_LIMIT   = phsss_pkg::CAPTURE_LIMIT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  phsss_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output phsss_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [22:0]         csr_wdata
);
   import phsss_pkg::*;

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;
   logic      advance;

   // advance the held tick when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   phsss_step #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS),
      .CAPTURE_LIMIT  (CAPTURE_LIMIT)
   ) u_step (
      .cfg      (cfg_ff),
      .state_cur(state_ff),
      .req      (in_data_ff),
      .state_nxt(state_in),
      .rsp      (rsp_in)
   );

   // sequencer state: commit only when the tick moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_APPROACH, spiral_radius: START_RADIUS_RST,
                       default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // CSR write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contact_threshold <= CONTACT_THRESHOLD_RST;
         cfg_ff.slide_threshold   <= SLIDE_THRESHOLD_RST;
         cfg_ff.approach_offset   <= APPROACH_OFFSET_RST;
         cfg_ff.contact_offset    <= CONTACT_OFFSET_RST;
         cfg_ff.slide_offset      <= SLIDE_OFFSET_RST;
         cfg_ff.start_radius      <= START_RADIUS_RST;
         cfg_ff.radius_step       <= RADIUS_STEP_RST;
         cfg_ff.angle_step        <= ANGLE_STEP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CONTACT_THRESHOLD: cfg_ff.contact_threshold <= csr_wdata[14:0];
            CSR_SLIDE_THRESHOLD:   cfg_ff.slide_threshold   <= $signed(csr_wdata[15:0]);
            CSR_APPROACH_OFFSET:   cfg_ff.approach_offset   <= csr_wdata;
            CSR_CONTACT_OFFSET:    cfg_ff.contact_offset    <= csr_wdata;
            CSR_SLIDE_OFFSET:      cfg_ff.slide_offset      <= csr_wdata;
            CSR_START_RADIUS:      cfg_ff.start_radius      <= csr_wdata;
            CSR_RADIUS_STEP:       cfg_ff.radius_step       <= csr_wdata;
            CSR_ANGLE_STEP:        cfg_ff.angle_step        <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // phase only moves forward outside reset
   a_phase_forward: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> state_ff.phase >= $past(state_ff.phase))
      else $error("sequencer phase moved backward");

   // a tick that advances always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced tick lost before result register");

   // an approach-phase result always drives X gain only
   a_approach_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.phase == PH_APPROACH |-> rsp_data_ff.gain_mask == GAIN_X_ONLY)
      else $error("approach result with wrong gain mask");

   // input stalls only when both registers are full and the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a full pipeline");

endmodule

// ===== verif/seq_check_pkg.sv =====
// Scoreboard for the peg-hole spiral search sequencer: a tick-by-tick
// predictor of target, gain and phase plus the queue of predicted responses.
// Depends on phsss_pkg for the transaction, register and phase types.
package seq_check_pkg;
   import phsss_pkg::*;

   localparam int LUT_BITS = SINE_TABLE_BITS_DEF;
   localparam int LUT_N = 1 << LUT_BITS;
   localparam int LUT_Q = LUT_N / 4;
   localparam longint RADIUS_TOP = 64'sd8388607;

   class tick_scoreboard;
      cfg_type            cfg;
      phase_type          phase;
      logic [3:0]         captures;
      logic [15:0]        angle;
      logic [22:0]        radius;
      logic signed [23:0] hit_y;
      logic signed [23:0] hit_z;
      rsp_type            prev_out;
      logic signed [15:0] sine_lut [LUT_N];
      rsp_type            target_queue [$];
      int                 mismatches;
      int                 checked;
      int                 reg_writes;
      int                 phase_ticks [4];

      function new();
         longint unsigned x, x2, t, s, v;
         int unsigned quad, step, q;
         // quarter-wave Taylor series in Q30, folded to a full turn
         for (int i = 0; i < LUT_N; i++) begin
            quad = i / LUT_Q;
            step = i % LUT_Q;
            q = (quad & 1) ? LUT_Q - step : step;
            x = (64'(q) * HALF_PI_Q30) / LUT_Q;
            x2 = (x * x) >> 30;
            t = ONE_Q30;
            for (int k = 0; k < 5; k++) begin
               t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[k];
            end
            s = (x * t) >> 30;
            v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
               v = 64'd32767;
            end
            sine_lut[i] = (quad & 2) ? -v[15:0] : v[15:0];
         end
         cfg.contact_threshold = CONTACT_THRESHOLD_RST;
         cfg.slide_threshold = SLIDE_THRESHOLD_RST;
         cfg.approach_offset = APPROACH_OFFSET_RST;
         cfg.contact_offset = CONTACT_OFFSET_RST;
         cfg.slide_offset = SLIDE_OFFSET_RST;
         cfg.start_radius = START_RADIUS_RST;
         cfg.radius_step = RADIUS_STEP_RST;
         cfg.angle_step = ANGLE_STEP_RST;
         phase = PH_APPROACH;
         captures = '0;
         angle = '0;
         radius = START_RADIUS_RST;
         hit_y = '0;
         hit_z = '0;
         prev_out = '0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [22:0] val);
         reg_writes++;
         case (idx)
            CSR_CONTACT_THRESHOLD: cfg.contact_threshold = val[14:0];
            CSR_SLIDE_THRESHOLD:   cfg.slide_threshold = val[15:0];
            CSR_APPROACH_OFFSET:   cfg.approach_offset = val;
            CSR_CONTACT_OFFSET:    cfg.contact_offset = val;
            CSR_SLIDE_OFFSET:      cfg.slide_offset = val;
            CSR_START_RADIUS:      cfg.start_radius = val;
            CSR_RADIUS_STEP:       cfg.radius_step = val;
            default:               cfg.angle_step = val[15:0];
         endcase
      endfunction

      function logic signed [23:0] clamp24(longint v);
         if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
         end
         if (v < -64'sd8388608) begin
            return 24'sh800000;
         end
         return v[23:0];
      endfunction

      // rad * s / 32768, rounded half away from zero
      function longint q15_mul(longint rad, longint s);
         longint mag, v;
         mag = rad * ((s < 0) ? -s : s);
         v = (mag + 64'sd16384) >>> 15;
         return (s < 0) ? -v : v;
      endfunction

      function int pending();
         return target_queue.size();
      endfunction

      // advance the sequencer by one accepted tick and queue its response
      function void take_tick(req_type it);
         longint fx, mag, r;
         bit light;
         rsp_type nxt;
         int unsigned a, idx, cidx;
         fx = it.force_x;
         mag = (fx < 0) ? -fx : fx;
         light = mag < longint'(cfg.contact_threshold);
         phase_ticks[phase]++;
         nxt = prev_out;
         case (phase)
            PH_APPROACH: begin
               if (light) begin
                  nxt.target_x = clamp24(longint'(it.pos_x) + longint'(cfg.approach_offset));
                  nxt.target_y = it.pos_y;
                  nxt.target_z = it.pos_z;
                  nxt.gain_mask = GAIN_X_ONLY;
               end else begin
                  phase = PH_SEARCH;
               end
            end
            PH_SEARCH: begin
               if (captures <= CAPTURE_LIMIT_DEF) begin
                  hit_y = it.pos_y;
                  hit_z = it.pos_z;
                  angle = '0;
                  radius = cfg.start_radius;
                  if (captures != COUNT_MAX) begin
                     captures++;
                  end
                  nxt.target_x = it.pos_x;
                  nxt.target_y = it.pos_y;
                  nxt.target_z = it.pos_z;
               end else begin
                  a = angle + cfg.angle_step;
                  if (a >= 65536) begin
                     r = longint'(radius) + longint'(cfg.radius_step);
                     radius = (r > RADIUS_TOP) ? RADIUS_TOP[22:0] : r[22:0];
                     a = 0;
                  end
                  angle = a[15:0];
                  idx = (a >> (16 - LUT_BITS)) % LUT_N;
                  cidx = (idx + LUT_Q) % LUT_N;
                  nxt.target_x = clamp24(longint'(it.pos_x) + longint'(cfg.contact_offset));
                  nxt.target_y = clamp24(longint'(hit_y) + q15_mul(radius, sine_lut[cidx]));
                  nxt.target_z = clamp24(longint'(hit_z) + q15_mul(radius, sine_lut[idx]));
               end
               nxt.gain_mask = GAIN_ALL;
               if (light) begin
                  phase = PH_SLIDE;
               end
            end
            PH_SLIDE: begin
               if (fx > longint'(cfg.slide_threshold)) begin
                  nxt.target_x = clamp24(longint'(it.pos_x) + longint'(cfg.slide_offset));
                  nxt.target_y = it.pos_y;
                  nxt.target_z = it.pos_z;
                  nxt.gain_mask = GAIN_ALL;
               end else begin
                  phase = PH_PRESS;
               end
            end
            default: begin
               nxt.target_x = clamp24(longint'(it.pos_x) + longint'(cfg.contact_offset));
               nxt.target_y = it.pos_y;
               nxt.target_z = it.pos_z;
               nxt.gain_mask = GAIN_ALL;
            end
         endcase
         nxt.phase = phase;
         prev_out = nxt;
         target_queue.push_back(nxt);
      endfunction

      function void check_tick(rsp_type got);
         rsp_type want;
         if (target_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected response: x %0d y %0d z %0d gain %h phase %0d",
                        got.target_x, got.target_y, got.target_z, got.gain_mask, got.phase);
            end
            return;
         end
         want = target_queue.pop_front();
         checked++;
         if (got.target_x !== want.target_x || got.target_y !== want.target_y ||
             got.target_z !== want.target_z || got.gain_mask !== want.gain_mask ||
             got.phase !== want.phase) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d mismatch: expected x %0d y %0d z %0d gain %h phase %0d",
                        checked, want.target_x, want.target_y, want.target_z,
                        want.gain_mask, want.phase);
               $display("   actual x %0d y %0d z %0d gain %h phase %0d",
                        got.target_x, got.target_y, got.target_z, got.gain_mask, got.phase);
            end
         end
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench for peg_hole_spiral_search_sequencer_core: drives ticks
// through the whole approach, search, slide and press sequence with random
// pacing. Depends on phsss_pkg and seq_check_pkg.
module tb_top;
   import phsss_pkg::*;
   import seq_check_pkg::*;

   localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] POS_MIN = 24'sh800000;
   localparam logic [22:0] FIELD23_MAX = 23'h7FFFFF;
   localparam int QUIET_LIMIT = 3000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [22:0] csr_wdata = '0;

   tick_scoreboard sb = new();
   bit burst;
   int quiet;

   peg_hole_spiral_search_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Random w-bit signed value, biased toward the ends of the range.
   function automatic longint rand_field(input int w);
      longint v;
      case ($urandom_range(0, 11))
         0: v = (longint'(1) << (w - 1)) - 1;
         1: v = -(longint'(1) << (w - 1));
         2: v = 0;
         3: v = -1;
         default: begin
            v = longint'($urandom());
            v = (v << (64 - w)) >>> (64 - w);
         end
      endcase
      return v;
   endfunction

   // Force whose magnitude stays under the contact threshold (ct >= 1).
   function automatic logic signed [15:0] light_force(input int ct);
      int mag;
      mag = ($urandom_range(0, 5) == 0) ? ct - 1 : $urandom_range(0, ct - 1);
      return 16'($urandom_range(0, 1) ? -mag : mag);
   endfunction

   // Force whose magnitude reaches the contact threshold.
   function automatic logic signed [15:0] heavy_force(input int ct);
      int mag;
      case ($urandom_range(0, 5))
         0: mag = ct;
         1: mag = 32768;
         default: mag = $urandom_range(ct, 32768);
      endcase
      if (mag == 32768) begin
         return 16'sh8000;
      end
      return 16'($urandom_range(0, 1) ? -mag : mag);
   endfunction

   // Present one tick and hold it until the block takes it. Valid stays high
   // into the next tick when no gap is drawn and drops for the gap otherwise.
   task automatic send_tick(input logic signed [15:0] f,
                            input logic signed [23:0] x, y, z);
      req_type it;
      int gap;
      it.force_x = f;
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      sb.take_tick(it);
   endtask

   // Drop valid and wait until every predicted response has been checked.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // CSRs change only with the pipeline empty.
   task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
      settle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Run n ticks that keep the current phase; with leave set, the last one
   // pushes the sequencer on to the next phase. Press takes any force.
   task automatic run_ticks(input int n, input bit leave);
      int ct, st, lo, hi;
      bit stay;
      logic signed [15:0] f;
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         ct = int'(sb.cfg.contact_threshold);
         st = int'(sb.cfg.slide_threshold);
         stay = !(leave && i == n - 1);
         case (sb.phase)
            PH_APPROACH: f = (stay && ct != 0) ? light_force(ct) : heavy_force(ct);
            PH_SEARCH:   f = (!stay && ct != 0) ? light_force(ct) : heavy_force(ct);
            PH_SLIDE: begin
               if (stay && st != 32767) begin
                  lo = st + 1;
                  hi = 32767;
               end else begin
                  lo = -32768;
                  hi = st;
               end
               case ($urandom_range(0, 5))
                  0: f = 16'(lo);
                  1: f = 16'(hi);
                  default: f = 16'(lo + int'($urandom_range(0, hi - lo)));
               endcase
            end
            default: f = 16'(rand_field(16));
         endcase
         send_tick(f, 24'(rand_field(24)), 24'(rand_field(24)), 24'(rand_field(24)));
      end
   endtask

   // Check every response transaction as it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_tick(rsp_data);
      end
   end

   // Response side: wait a random number of cycles before taking each one.
   initial begin : rsp_pacing
      int gap;
      forever begin
         gap = burst ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Abort when nothing moves on either channel or the CSR port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Approach at reset settings: threshold edges and position extremes,
      // the second of them saturating the X lead.
      send_tick(16'sd0, 24'sd0, 24'sd0, 24'sd0);
      send_tick(16'sd63, POS_MAX, POS_MIN, -24'sd1);
      send_tick(-16'sd63, POS_MIN, POS_MAX, 24'sd0);
      write_reg(CSR_CONTACT_THRESHOLD, 23'd32767);
      write_reg(CSR_APPROACH_OFFSET, FIELD23_MAX);
      send_tick(16'sd32766, POS_MAX, 24'sd1, -24'sd1);
      send_tick(-16'sd32766, POS_MIN, -24'sd1, 24'sd1);
      write_reg(CSR_APPROACH_OFFSET, 23'd0);
      // start radius is only loaded during capture, so its extremes are
      // harmless here
      write_reg(CSR_START_RADIUS, 23'd0);
      write_reg(CSR_START_RADIUS, FIELD23_MAX);
      send_tick(-16'sd1, 24'sd12345, -24'sd54321, 24'sd777);

      // Random approach under a few thresholds, the tightest one first.
      for (int k = 0; k < 3; k++) begin
         write_reg(CSR_CONTACT_THRESHOLD, (k == 0) ? 23'd1 : 23'($urandom_range(2, 4000)));
         write_reg(CSR_APPROACH_OFFSET, 23'($urandom_range(0, FIELD23_MAX)));
         run_ticks(38, 1'b0);
      end

      // Set up the spiral, then make contact.
      write_reg(CSR_START_RADIUS, 23'($urandom_range(2000, 400000)));
      write_reg(CSR_RADIUS_STEP, 23'($urandom_range(1000, 100000)));
      write_reg(CSR_ANGLE_STEP, 23'd8192);
      write_reg(CSR_CONTACT_OFFSET, 23'($urandom_range(0, 200000)));
      run_ticks(1, 1'b1);

      // Search: capture ticks, then a fast spiral with several turns.
      write_reg(CSR_CONTACT_THRESHOLD, 23'd0);
      run_ticks(40, 1'b0);
      // wrap on every other tick
      write_reg(CSR_ANGLE_STEP, 23'd65535);
      run_ticks(16, 1'b0);
      // hold the angle still
      write_reg(CSR_ANGLE_STEP, 23'd0);
      run_ticks(8, 1'b0);
      write_reg(CSR_ANGLE_STEP, 23'd1);
      write_reg(CSR_CONTACT_OFFSET, FIELD23_MAX);
      run_ticks(8, 1'b0);
      for (int k = 0; k < 4; k++) begin
         write_reg(CSR_ANGLE_STEP, 23'($urandom_range(1, 65535)));
         write_reg(CSR_RADIUS_STEP, 23'($urandom_range(0, 200000)));
         write_reg(CSR_CONTACT_OFFSET, 23'($urandom_range(0, FIELD23_MAX)));
         write_reg(CSR_CONTACT_THRESHOLD, 23'($urandom_range(1, 32767)));
         run_ticks(20, 1'b0);
      end
      // drive the radius into saturation
      write_reg(CSR_RADIUS_STEP, FIELD23_MAX);
      write_reg(CSR_ANGLE_STEP, 23'd30000);
      write_reg(CSR_CONTACT_THRESHOLD, 23'd32767);
      run_ticks(16, 1'b0);
      write_reg(CSR_CONTACT_OFFSET, 23'd0);
      write_reg(CSR_RADIUS_STEP, 23'd0);
      run_ticks(10, 1'b0);
      // a light tick ends the search
      write_reg(CSR_CONTACT_THRESHOLD, 23'($urandom_range(100, 5000)));
      run_ticks(1, 1'b1);

      // Slide, starting from the lowest threshold.
      write_reg(CSR_SLIDE_OFFSET, FIELD23_MAX);
      write_reg(CSR_SLIDE_THRESHOLD, 23'(16'h8000));
      run_ticks(20, 1'b0);
      write_reg(CSR_SLIDE_OFFSET, 23'd0);
      write_reg(CSR_SLIDE_THRESHOLD, 23'(16'($urandom_range(0, 65534) - 32768)));
      run_ticks(20, 1'b0);
      for (int k = 0; k < 3; k++) begin
         write_reg(CSR_SLIDE_THRESHOLD, 23'(16'($urandom_range(0, 65534) - 32768)));
         write_reg(CSR_SLIDE_OFFSET, 23'($urandom_range(0, FIELD23_MAX)));
         run_ticks(20, 1'b0);
      end
      run_ticks(1, 1'b1);

      // Press holds for good; feed it arbitrary force.
      write_reg(CSR_SLIDE_THRESHOLD, 23'd32767);
      for (int k = 0; k < 3; k++) begin
         write_reg(CSR_CONTACT_OFFSET, (k == 0) ? FIELD23_MAX :
                   23'($urandom_range(0, FIELD23_MAX)));
         write_reg(CSR_CONTACT_THRESHOLD, 23'($urandom_range(0, 32767)));
         run_ticks(30, 1'b0);
      end

      settle();
      repeat (8) @(posedge clock);
      $display("Ran %0d ticks (approach %0d, search %0d, slide %0d, press %0d), %0d CSR writes",
               sb.phase_ticks[0] + sb.phase_ticks[1] + sb.phase_ticks[2] + sb.phase_ticks[3],
               sb.phase_ticks[0], sb.phase_ticks[1], sb.phase_ticks[2], sb.phase_ticks[3],
               sb.reg_writes);
      $display("Checked %0d responses, %0d mismatches, %0d outstanding",
               sb.checked, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
